// ===== hdl/apsp_pkg.sv =====
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types and constants for the all-pairs shortest path block.
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int WEIGHT_BITS  = 16;
    localparam int DIST_BITS    = 24;
    localparam int VB           = $clog2(MAX_VERTICES);
    localparam int CELLS        = MAX_VERTICES * MAX_VERTICES;
    localparam int CB           = 2 * VB;
    localparam int HB           = DIST_BITS + 8;   // wide working width

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_COMPUTE = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_COMPUTE = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CLR,
        ST_BF,
        ST_CHK,
        ST_POT,
        ST_DINIT,
        ST_DSEL,
        ST_DREL,
        ST_DOUT,
        ST_DONE
    } state_t;

    function automatic logic signed [DIST_BITS-1:0] sat_dist(input logic signed [HB-1:0] x);
        logic signed [HB-1:0] hi;
        logic signed [HB-1:0] lo;
        hi = HB'((64'sd1 <<< (DIST_BITS - 1)) - 64'sd1);
        lo = -hi - HB'(1);
        if (x > hi)
            return hi[DIST_BITS-1:0];
        else if (x < lo)
            return lo[DIST_BITS-1:0];
        else
            return x[DIST_BITS-1:0];
    endfunction

endpackage

// ===== hdl/apsp_ram.sv =====
// ----------------------------------------------------------------------------
// apsp_ram
// Generic single-port-write, one-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module apsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/all_pairs_shortest_paths.sv =====
// ----------------------------------------------------------------------------
// all_pairs_shortest_paths
// Johnson all-pairs shortest paths over a memory-held adjacency matrix.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low. A load marks its
// result in the next cycle; a read passes through ST_READ first. A compute
// request runs a clearing pass over the whole distance store (MAX_VERTICES
// squared entries), Bellman-Ford with N passes over all edge slots, each edge
// taking an address phase and a data phase, a negative cycle check, then,
// unless a negative cycle was found, a Dijkstra per source: up to N selection
// sweeps over N vertices, each followed by an N-edge relaxation in the same
// two phases. These phases are set by the single read port of the edge
// memory. The strobe done marks each result for one cycle; the receiver
// cannot stall, so results are never held. Reads issued before the first
// compute give 0 / unreachable. Potentials and tentative distances sit in
// small register files indexed by the sweep counters.
module all_pairs_shortest_paths
    import apsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [3:0]         src_vertex,
    input  logic [3:0]         dst_vertex,
    input  logic signed [15:0] edge_weight,
    input  logic               edge_present,
    output logic               done,
    output logic [1:0]         kind,
    output logic signed [23:0] path_length,
    output logic               reachable,
    output logic               negative_cycle
);

    state_t state_reg, state_next;
    logic [4:0] vcount_reg;
    logic [VB:0] n;
    logic cfg_wr;

    // edge memory: {present, weight}; present cleared by valid bits
    logic [CELLS-1:0] pvalid_reg;
    logic e_we;
    logic [CB-1:0] e_waddr, e_raddr;
    logic [WEIGHT_BITS:0] e_wdata, e_rdata;
    // distance memory: {reach, dist}
    logic d_we;
    logic [CB-1:0] d_waddr, d_raddr;
    logic [DIST_BITS:0] d_wdata, d_rdata;

    logic signed [HB-1:0] h_reg [MAX_VERTICES];
    logic signed [HB-1:0] td_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] tv_reg, st_reg;
    logic cyc_reg;

    logic [VB:0] i_reg, u_reg, v_reg, src_reg;
    logic [VB-1:0] best_reg;
    logic bvalid_reg;
    logic ph_reg;     // 0: address issued, 1: data back
    logic [CB-1:0] cidx_reg;
    logic dvalid_reg; // distance store cleared at least once

    logic done_reg;
    logic [1:0] kind_reg;
    logic signed [23:0] len_reg;
    logic reach_reg;

    apsp_ram #(.WIDTH(WEIGHT_BITS + 1), .DEPTH(CELLS)) u_edge (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata));
    apsp_ram #(.WIDTH(DIST_BITS + 1), .DEPTH(CELLS)) u_dist (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata));

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? {27'd0, vcount_reg} : 32'd0;
    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign kind = kind_reg;
    assign path_length = len_reg;
    assign reachable = reach_reg;
    assign negative_cycle = cyc_reg;

    always_comb
    begin
        if (vcount_reg == 5'd0)
            n = (VB+1)'(1);
        else if (vcount_reg > 5'(MAX_VERTICES))
            n = (VB+1)'(MAX_VERTICES);
        else
            n = vcount_reg[VB:0];
    end

    logic accept;
    assign accept = start && !busy;

    // edge data as seen this cycle
    logic e_pres;
    logic signed [HB-1:0] e_w;
    assign e_pres = e_rdata[WEIGHT_BITS] && pvalid_reg[cidx_reg];
    assign e_w = HB'($signed(e_rdata[WEIGHT_BITS-1:0]));

    // relax candidate values
    logic [VB-1:0] uu, vv, bb;
    assign uu = u_reg[VB-1:0];
    assign vv = v_reg[VB-1:0];
    assign bb = best_reg;
    logic signed [HB-1:0] bf_cand, dj_cand;
    assign bf_cand = h_reg[uu] + e_w;
    assign dj_cand = td_reg[bb] + e_w + h_reg[bb] - h_reg[vv];

    always_comb
    begin
        state_next = state_reg;
        e_we = 1'b0;
        e_waddr = {src_vertex, dst_vertex};
        e_wdata = {edge_present, edge_weight};
        e_raddr = {uu, vv};
        d_we = 1'b0;
        d_waddr = {uu, vv};
        d_wdata = '0;
        d_raddr = {src_vertex, dst_vertex};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_LOAD:    e_we = 1'b1;
                        ACT_COMPUTE: state_next = ST_CLR;
                        ACT_READ:    state_next = ST_READ;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ: state_next = ST_IDLE;
            ST_CLR:
            begin
                d_we = 1'b1;
                if (u_reg == (VB+1)'(MAX_VERTICES-1) && v_reg == (VB+1)'(MAX_VERTICES-1))
                    state_next = ST_BF;
            end
            ST_BF:
            begin
                if (ph_reg && i_reg == n - 1'b1 && u_reg == n - 1'b1 && v_reg == n - 1'b1)
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (ph_reg && u_reg == n - 1'b1 && v_reg == n - 1'b1)
                    state_next = ST_POT;
            end
            ST_POT: state_next = cyc_reg ? ST_DONE : ST_DINIT;
            ST_DINIT: state_next = ST_DSEL;
            ST_DSEL:
            begin
                if (v_reg == n - 1'b1)
                    state_next = ST_DREL;
            end
            ST_DREL:
            begin
                e_raddr = {bb, vv};
                if (!bvalid_reg)
                    state_next = ST_DOUT;
                else if (ph_reg && v_reg == n - 1'b1)
                    state_next = (i_reg == n - 1'b1) ? ST_DOUT : ST_DSEL;
            end
            ST_DOUT:
            begin
                d_we = tv_reg[vv];
                d_waddr = {src_reg[VB-1:0], vv};
                d_wdata = {1'b1, sat_dist(td_reg[vv] + h_reg[vv] - h_reg[src_reg[VB-1:0]])};
                if (v_reg == n - 1'b1)
                    state_next = (src_reg == n - 1'b1) ? ST_DONE : ST_DINIT;
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vcount_reg <= 5'd16;
            pvalid_reg <= '0;
            cyc_reg <= 1'b0;
            done_reg <= 1'b0;
            kind_reg <= KIND_LOAD;
            len_reg <= '0;
            reach_reg <= 1'b0;
            ph_reg <= 1'b0;
            i_reg <= '0;
            u_reg <= '0;
            v_reg <= '0;
            src_reg <= '0;
            tv_reg <= '0;
            st_reg <= '0;
            best_reg <= '0;
            bvalid_reg <= 1'b0;
            cidx_reg <= '0;
            dvalid_reg <= 1'b0;
            for (int k = 0; k < MAX_VERTICES; k++)
            begin
                h_reg[k] <= '0;
                td_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= (state_reg == ST_IDLE && accept && action == ACT_LOAD) ||
                        (state_reg == ST_READ) || (state_reg == ST_DONE);
            if (cfg_wr)
                vcount_reg <= pwdata[4:0];
            cidx_reg <= e_raddr;
            case (state_reg)
                ST_IDLE:
                begin
                    u_reg <= '0;
                    v_reg <= '0;
                    i_reg <= '0;
                    ph_reg <= 1'b0;
                    if (accept && action == ACT_LOAD)
                    begin
                        pvalid_reg[{src_vertex, dst_vertex}] <= 1'b1;
                        kind_reg <= KIND_LOAD;
                        len_reg <= '0;
                        reach_reg <= 1'b0;
                    end
                end
                ST_READ:
                begin
                    kind_reg <= KIND_READ;
                    len_reg <= dvalid_reg ? d_rdata[DIST_BITS-1:0] : '0;
                    reach_reg <= dvalid_reg & d_rdata[DIST_BITS];
                end
                ST_CLR:
                begin
                    if (state_next == ST_BF)
                    begin
                        u_reg <= '0;
                        v_reg <= '0;
                        dvalid_reg <= 1'b1;
                        for (int k = 0; k < MAX_VERTICES; k++)
                            h_reg[k] <= '0;
                    end
                    else if (v_reg == (VB+1)'(MAX_VERTICES-1))
                    begin
                        v_reg <= '0;
                        u_reg <= u_reg + 1'b1;
                    end
                    else
                        v_reg <= v_reg + 1'b1;
                end
                ST_BF, ST_CHK:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (e_pres && bf_cand < h_reg[vv])
                        begin
                            if (state_reg == ST_BF)
                                h_reg[vv] <= bf_cand;
                            else
                                cyc_reg <= 1'b1;
                        end
                        if (v_reg == n - 1'b1)
                        begin
                            v_reg <= '0;
                            if (u_reg == n - 1'b1)
                            begin
                                u_reg <= '0;
                                i_reg <= (state_reg == ST_BF && i_reg != n - 1'b1) ?
                                    i_reg + 1'b1 : '0;
                            end
                            else
                                u_reg <= u_reg + 1'b1;
                        end
                        else
                            v_reg <= v_reg + 1'b1;
                    end
                    else if (state_reg == ST_BF && i_reg == '0 && u_reg == '0
                             && v_reg == '0)
                        cyc_reg <= 1'b0;
                end
                ST_POT:
                begin
                    src_reg <= '0;
                    for (int k = 0; k < MAX_VERTICES; k++)
                        h_reg[k] <= (k < n) ? HB'(sat_dist(h_reg[k])) : '0;
                end
                ST_DINIT:
                begin
                    tv_reg <= MAX_VERTICES'(1) << src_reg[VB-1:0];
                    st_reg <= '0;
                    td_reg[src_reg[VB-1:0]] <= '0;
                    v_reg <= '0;
                    i_reg <= '0;
                    bvalid_reg <= 1'b0;
                end
                ST_DSEL:
                begin
                    if (tv_reg[vv] && !st_reg[vv] &&
                        (!bvalid_reg || td_reg[vv] < td_reg[bb]))
                    begin
                        best_reg <= vv;
                        bvalid_reg <= 1'b1;
                    end
                    v_reg <= (v_reg == n - 1'b1) ? '0 : v_reg + 1'b1;
                    ph_reg <= 1'b0;
                end
                ST_DREL:
                begin
                    if (bvalid_reg)
                    begin
                        st_reg[bb] <= 1'b1;
                        ph_reg <= !ph_reg;
                        if (ph_reg)
                        begin
                            if (e_pres && (!tv_reg[vv] || dj_cand < td_reg[vv]))
                            begin
                                td_reg[vv] <= dj_cand;
                                tv_reg[vv] <= 1'b1;
                            end
                            if (v_reg == n - 1'b1)
                            begin
                                v_reg <= '0;
                                i_reg <= i_reg + 1'b1;
                                bvalid_reg <= 1'b0;
                            end
                            else
                                v_reg <= v_reg + 1'b1;
                        end
                    end
                    else
                        v_reg <= '0;
                end
                ST_DOUT:
                begin
                    if (v_reg == n - 1'b1)
                    begin
                        v_reg <= '0;
                        src_reg <= src_reg + 1'b1;
                    end
                    else
                        v_reg <= v_reg + 1'b1;
                end
                ST_DONE:
                begin
                    kind_reg <= KIND_COMPUTE;
                    len_reg <= '0;
                    reach_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (kind == KIND_LOAD || kind == KIND_COMPUTE || kind == KIND_READ))
        else $error("result with an unknown kind");
    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind != KIND_READ) |-> (path_length == '0 && !reachable))
        else $error("non-read result carries a distance");
    a_busy_compute: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> (done && kind == KIND_COMPUTE))
        else $error("compute finished without result");

endmodule
